[rtl/core/tpbh_pkg.sv]
// shared types and constants for the three-plane byte histogram
package tpbh_pkg;

  localparam int PLANE_COUNT     = 3;
  localparam int BINS_PER_PLANE  = 256;
  localparam int BIN_DEPTH       = PLANE_COUNT * BINS_PER_PLANE;
  localparam int PLANE_W         = 2;
  localparam int VALUE_W         = 8;
  localparam int ADDR_W          = PLANE_W + VALUE_W;
  localparam int OUT_W           = 32;
  localparam int COUNT_WIDTH_DEF = 32;

  typedef enum logic {
    MODE_COUNT = 1'b0,
    MODE_READ  = 1'b1
  } mode_t;

  typedef enum logic {
    PH_CLEAR,
    PH_RUN
  } phase_t;

endpackage

[rtl/core/tpbh_ram.sv]
// generic simple dual-port ram with registered read
module tpbh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/tpbh_out_fifo.sv]
// two-entry result queue between the update stage and the result channel
module tpbh_out_fifo #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] head,
  output logic [1:0]       occ
);

  logic [WIDTH-1:0] d0_r, d0_nxt;
  logic [WIDTH-1:0] d1_r, d1_nxt;
  logic [1:0]       occ_r, occ_nxt;

  always_comb begin
    d0_nxt  = d0_r;
    d1_nxt  = d1_r;
    occ_nxt = occ_r;
    case ({push, pop})
      2'b01: begin
        d0_nxt  = d1_r;
        occ_nxt = occ_r - 2'd1;
      end
      2'b10: begin
        if (occ_r == 2'd0) begin
          d0_nxt = push_data;
        end else begin
          d1_nxt = push_data;
        end
        occ_nxt = occ_r + 2'd1;
      end
      2'b11: begin
        if (occ_r == 2'd1) begin
          d0_nxt = push_data;
        end else begin
          d0_nxt = d1_r;
          d1_nxt = push_data;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 2'd0;
    end else begin
      occ_r <= occ_nxt;
    end
    d0_r <= d0_nxt;
    d1_r <= d1_nxt;
  end

  assign valid = (occ_r != 2'd0);
  assign head  = d0_r;
  assign occ   = occ_r;

endmodule

[rtl/core/three_plane_byte_histogram.sv]
// three 256-bin histograms in one bin ram, with saturating read-modify-write
// a read result is registered in the update stage and then in the result queue before it can transfer
// throughput: one item per cycle while in_ready is high, read-modify-write through the bin ram with forwarding
// a full result queue holds off new items until the result side drains
// reset: a clearing pass writes zero to all 768 bins, one per cycle
// in_ready stays low during the clearing pass
module three_plane_byte_histogram
  import tpbh_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [0:0]         in_mode,
  input  logic [PLANE_W-1:0] in_plane,
  input  logic [VALUE_W-1:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [OUT_W-1:0]   out_count
);

  // clearing pass sequencer
  phase_t            phase_r, phase_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic              clearing;

  // update stage, holds the item whose bin read is returning
  logic                   s1_valid_r;
  mode_t                  s1_mode_r;
  logic                   s1_ok_r;
  logic [ADDR_W-1:0]      s1_addr_r;
  logic                   fwd_r, fwd_nxt;
  logic [COUNT_WIDTH-1:0] fwd_data_r;

  logic                   accept;
  logic                   in_ok;
  logic [ADDR_W-1:0]      in_addr;
  logic [COUNT_WIDTH-1:0] ram_rdata;
  logic [COUNT_WIDTH-1:0] cur_count;
  logic [COUNT_WIDTH-1:0] inc_count;
  logic [OUT_W-1:0]       rd_count;
  logic                   s1_wr;
  logic                   s1_rd;

  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_waddr;
  logic [COUNT_WIDTH-1:0] ram_wdata;

  logic                   q_push;
  logic [OUT_W-1:0]       q_data;
  logic                   q_pop;
  logic [1:0]             q_occ;
  logic [2:0]             q_occ_next;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_CLEAR: begin
        if (clr_cnt_r == ADDR_W'(BIN_DEPTH - 1)) begin
          phase_nxt = PH_RUN;
        end
      end
      PH_RUN:   phase_nxt = PH_RUN;
      default:  phase_nxt = PH_CLEAR;
    endcase
  end

  // phase outputs
  always_comb begin
    clearing    = 1'b0;
    clr_cnt_nxt = clr_cnt_r;
    case (phase_r)
      PH_CLEAR: begin
        clearing    = 1'b1;
        clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      phase_r   <= phase_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  // input side: the unused fourth plane reads bin 0 and never writes
  assign in_ok   = (in_plane < PLANE_W'(PLANE_COUNT));
  assign in_addr = in_ok ? {in_plane, in_value} : '0;
  assign accept  = in_valid && in_ready;

  // room check: the item in the update stage lands in the queue next cycle
  assign q_pop      = out_valid && out_ready;
  assign q_occ_next = {1'b0, q_occ} + {2'b00, s1_rd} - {2'b00, q_pop};
  assign in_ready   = !clearing && (q_occ_next < 3'd2);

  // forward the value being written when the next item hits the same bin
  assign fwd_nxt = accept && s1_wr && (in_addr == s1_addr_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
    end else begin
      s1_valid_r <= accept;
      fwd_r      <= fwd_nxt;
    end
    s1_mode_r  <= mode_t'(in_mode);
    s1_ok_r    <= in_ok;
    s1_addr_r  <= in_addr;
    fwd_data_r <= inc_count;
  end

  // saturating increment
  assign cur_count = fwd_r ? fwd_data_r : ram_rdata;
  assign inc_count = (cur_count == '1) ? cur_count : cur_count + COUNT_WIDTH'(1);

  assign s1_wr = s1_valid_r && (s1_mode_r == MODE_COUNT) && s1_ok_r;
  assign s1_rd = s1_valid_r && (s1_mode_r == MODE_READ);

  // report width: clamp wide counters, zero-extend narrow ones
  generate
    if (COUNT_WIDTH > OUT_W) begin : g_wide
      assign rd_count = (|cur_count[COUNT_WIDTH-1:OUT_W]) ? '1 : cur_count[OUT_W-1:0];
    end else begin : g_narrow
      assign rd_count = OUT_W'(cur_count);
    end
  endgenerate

  assign q_push = s1_rd;
  assign q_data = s1_ok_r ? rd_count : '0;

  // bin ram write port is shared by the clearing pass and the update stage
  assign ram_we    = clearing || s1_wr;
  assign ram_waddr = clearing ? clr_cnt_r : s1_addr_r;
  assign ram_wdata = clearing ? '0 : inc_count;

  tpbh_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (BIN_DEPTH)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  tpbh_out_fifo #(
    .WIDTH (OUT_W)
  ) u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .valid     (out_valid),
    .head      (out_count),
    .occ       (q_occ)
  );

endmodule

[rtl/core/tpbh_checker.sv]
// port-level checks for the three-plane byte histogram, bound to the top level
module tpbh_checker
  import tpbh_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic [0:0]         in_mode,
  input logic               out_valid,
  input logic               out_ready,
  input logic [OUT_W-1:0]   out_count
);

  // no items taken in the cycle after reset, the clearing pass is running
  a_no_accept_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("item accepted right after reset");

  // queue comes up empty
  a_out_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_count))
    else $error("stalled result changed");

  // an empty queue only fills from a read item that has gone through the update stage register
  a_out_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && (in_mode == MODE_READ), 2))
    else $error("result without a read transfer");

endmodule

bind three_plane_byte_histogram tpbh_checker u_tpbh_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_mode   (in_mode),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_count (out_count)
);

[dv/bin_count_tracker.sv]
`timescale 1ns / 100ps
// channel watcher that mirrors the three bin planes and checks every read result
module bin_count_tracker
  import tpbh_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [0:0]         in_mode,
  input  logic [PLANE_W-1:0] in_plane,
  input  logic [VALUE_W-1:0] in_value,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [OUT_W-1:0]   out_count,
  output int                 count_errors,
  output int                 counts_due
);

  localparam logic [63:0] OUT_LIMIT = {{(64 - OUT_W){1'b0}}, {OUT_W{1'b1}}};

  logic [COUNT_WIDTH-1:0] bin_tally [BIN_DEPTH];
  logic [OUT_W-1:0]       due_counts [$];
  logic [OUT_W-1:0]       want;
  logic [ADDR_W-1:0]      slot;
  int                     errors = 0;

  // wide counters are reported clipped to the result width
  function automatic logic [OUT_W-1:0] clamp_count(logic [COUNT_WIDTH-1:0] tally);
    logic [63:0] wide;
    wide = 64'(tally);
    if (wide > OUT_LIMIT) return '1;
    return wide[OUT_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (bin_tally[i]) bin_tally[i] = '0;
      due_counts.delete();
    end else begin
      // result side first: a read never returns in the cycle it is taken
      if (out_valid && out_ready) begin
        if (due_counts.size() == 0) begin
          errors++;
          $display("%0t: stray result, expected nothing, actual count %0d", $time,
                   out_count);
        end else begin
          want = due_counts.pop_front();
          if (out_count !== want) begin
            errors++;
            $display("%0t: count mismatch, expected %0d, actual %0d", $time, want,
                     out_count);
          end
        end
      end
      if (in_valid && in_ready) begin
        slot = {in_plane, in_value};
        if (mode_t'(in_mode) == MODE_READ) begin
          due_counts.push_back(in_plane < PLANE_W'(PLANE_COUNT) ?
                               clamp_count(bin_tally[slot]) : '0);
        end else if (in_plane < PLANE_W'(PLANE_COUNT) && bin_tally[slot] != '1) begin
          bin_tally[slot] = bin_tally[slot] + COUNT_WIDTH'(1);
        end
      end
    end
    count_errors <= errors;
    counts_due   <= due_counts.size();
  end

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps
// top of the histogram testbench: stimulus, handshake pacing and final verdict
module tb;
  import tpbh_pkg::*;

  // narrow 16-bit counters, reported zero-extended on the 32-bit result
  localparam int CNT_W        = 16;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 1379;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int TAIL_CYCLES  = 16;

  // plane codes; the fourth code names no histogram
  localparam logic [PLANE_W-1:0] PLANE_Y      = 2'd0;
  localparam logic [PLANE_W-1:0] PLANE_CB     = 2'd1;
  localparam logic [PLANE_W-1:0] PLANE_CR     = 2'd2;
  localparam logic [PLANE_W-1:0] PLANE_UNUSED = 2'd3;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [0:0]         in_mode;
  logic [PLANE_W-1:0] in_plane;
  logic [VALUE_W-1:0] in_value;
  logic               out_valid;
  logic               out_ready;
  logic [OUT_W-1:0]   out_count;

  int count_errors;
  int counts_due;
  int cycle_count = 0;

  // pacing knobs for the two sides, set by the stimulus side
  bit send_idle;
  bit recv_idle;
  bit hold_results;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  three_plane_byte_histogram #(
    .COUNT_WIDTH(CNT_W)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_mode  (in_mode),
    .in_plane (in_plane),
    .in_value (in_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_count(out_count)
  );

  bin_count_tracker #(
    .COUNT_WIDTH(CNT_W)
  ) i_tracker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_mode     (in_mode),
    .in_plane    (in_plane),
    .in_value    (in_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_count   (out_count),
    .count_errors(count_errors),
    .counts_due  (counts_due)
  );

  // hard stop; covers the clearing pass and the longest stalls many times over
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // offer one item, with an optional idle gap first; returns in the step of its transfer
  task automatic offer_item(input mode_t mode, input logic [PLANE_W-1:0] plane,
                            input logic [VALUE_W-1:0] value);
    int gap;
    gap = send_idle ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode  <= mode;
    in_plane <= plane;
    in_value <= value;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  // stop offering until every pending read has returned its count
  task automatic wait_for_counts();
    in_valid <= 1'b0;
    do @(posedge clk); while (counts_due != 0);
  endtask

  // mostly counts on real planes, a fair share of reads, some unused-plane traffic;
  // a third of the values land on four hot values in each plane so counts climb
  task automatic pick_item(output mode_t mode, output logic [PLANE_W-1:0] plane,
                           output logic [VALUE_W-1:0] value);
    mode  = ($urandom_range(0, 99) < 30) ? MODE_READ : MODE_COUNT;
    plane = ($urandom_range(0, 99) < 8) ? PLANE_UNUSED :
            PLANE_W'($urandom_range(0, PLANE_COUNT - 1));
    value = ($urandom_range(0, 2) == 0) ? VALUE_W'($urandom_range(0, 3) * 85) :
            VALUE_W'($urandom);
  endtask

  // result side: random stalls per transfer, or one long hold when asked
  initial begin : result_side
    int stall;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_results) begin
        hold_results = 1'b0;
        stall = HOLD_CYCLES;
      end else begin
        stall = recv_idle ? $urandom_range(0, 16) : 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // stimulus side
  initial begin : item_side
    mode_t              pick_mode;
    logic [PLANE_W-1:0] pick_plane;
    logic [VALUE_W-1:0] pick_value;
    int                 issued;

    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_mode      = MODE_COUNT;
    in_plane     = PLANE_Y;
    in_value     = '0;
    send_idle    = 1'b0;
    recv_idle    = 1'b1;
    hold_results = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: fresh bins read zero, edge bins, the unused plane, back-to-back
    // count then read of one bin to hit the forwarding path
    offer_item(MODE_READ,  PLANE_Y,      8'h00);
    offer_item(MODE_READ,  PLANE_CR,     8'hFF);
    offer_item(MODE_COUNT, PLANE_Y,      8'h00);
    offer_item(MODE_COUNT, PLANE_Y,      8'hFF);
    offer_item(MODE_COUNT, PLANE_CB,     8'h80);
    offer_item(MODE_COUNT, PLANE_CR,     8'hFF);
    offer_item(MODE_COUNT, PLANE_CR,     8'hFF);
    offer_item(MODE_COUNT, PLANE_UNUSED, 8'hFF);
    offer_item(MODE_COUNT, PLANE_UNUSED, 8'h00);
    offer_item(MODE_READ,  PLANE_UNUSED, 8'h00);
    offer_item(MODE_READ,  PLANE_UNUSED, 8'hFF);
    offer_item(MODE_READ,  PLANE_Y,      8'h00);
    offer_item(MODE_READ,  PLANE_Y,      8'hFF);
    offer_item(MODE_READ,  PLANE_CB,     8'h80);
    offer_item(MODE_READ,  PLANE_CR,     8'hFF);
    offer_item(MODE_READ,  PLANE_CB,     8'hFF);
    offer_item(MODE_COUNT, PLANE_CB,     8'h7F);
    offer_item(MODE_READ,  PLANE_CB,     8'h7F);
    offer_item(MODE_READ,  PLANE_Y,      8'h01);
    offer_item(MODE_COUNT, PLANE_Y,      8'h00);
    offer_item(MODE_READ,  PLANE_Y,      8'h00);
    offer_item(MODE_COUNT, PLANE_CR,     8'hFF);
    offer_item(MODE_READ,  PLANE_CR,     8'hFF);
    wait_for_counts();

    // backpressure: result side holds off while reads keep coming, so the
    // block's result queue fills and in_ready must drop
    hold_results = 1'b1;
    for (int i = 0; i < 48; i++) begin
      offer_item(MODE_READ, PLANE_W'($urandom_range(0, 3)), VALUE_W'($urandom));
    end
    wait_for_counts();

    // random traffic in blocks, each block with its own idle pattern
    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      if (issued % 100 == 0) begin
        if ($urandom_range(0, 3) == 0) wait_for_counts();
        send_idle = ($urandom_range(0, 3) != 0);
        recv_idle = ($urandom_range(0, 3) != 0);
      end
      pick_item(pick_mode, pick_plane, pick_value);
      offer_item(pick_mode, pick_plane, pick_value);
      issued++;
    end
    wait_for_counts();

    // let any late or stray transfer show up before the verdict
    repeat (TAIL_CYCLES) @(posedge clk);
    if (count_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/tpbh_pkg.sv
rtl/core/tpbh_ram.sv
rtl/core/tpbh_out_fifo.sv
rtl/core/three_plane_byte_histogram.sv
rtl/core/tpbh_checker.sv
dv/bin_count_tracker.sv
dv/tb.sv
